@@ sv/jtag_bit_bang_command_engine_assert.svh @@
// Assertion macros used by the back end of the JTAG bit-bang command engine.
`ifndef JTAG_BIT_BANG_COMMAND_ENGINE_ASSERT_SVH
`define JTAG_BIT_BANG_COMMAND_ENGINE_ASSERT_SVH

// The condition must never hold outside reset.
`define JBBCE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define JBBCE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JBBCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jbbce_pkg.sv @@
// Shared types, command codes and defaults of the JTAG bit-bang command engine.
package jbbce_pkg;

  localparam int MAX_DATA_BYTES_DEF = 30;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int MAX_PAIRS          = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] CMD_INVALID    = 8'h00;
  localparam logic [7:0] CMD_GET_BOARD  = 8'h01;
  localparam logic [7:0] CMD_RESET      = 8'h02;
  localparam logic [7:0] CMD_BOOTLOADER = 8'h03;
  localparam logic [7:0] CMD_CLOCK_BITS = 8'h21;

  localparam logic [2:0] FEAT_SYSTEM_RESET = 3'b001;
  localparam logic [2:0] FEAT_BOOTLOADER   = 3'b100;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_VER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FW_VER    = 2'd3;

  localparam logic [15:0] SETTLE_RST    = 16'd25;
  localparam logic [15:0] RESPONSE_RST  = 16'd50;
  localparam logic [15:0] BOARD_VER_RST = 16'h0001;
  localparam logic [15:0] FW_VER_RST    = 16'h0001;

  localparam logic [2:0] KIND_INVALID   = 3'd0;
  localparam logic [2:0] KIND_GET_BOARD = 3'd1;
  localparam logic [2:0] KIND_RESET     = 3'd2;
  localparam logic [2:0] KIND_BOOT      = 3'd3;
  localparam logic [2:0] KIND_CLOCK     = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic       sys_reset;
    logic [2:0] npairs;
    logic [3:0] tdo;
    logic       eop;
  } cmd_entry_t;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] response_ticks;
    logic [15:0] board_version;
    logic [15:0] fw_version;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0]  response_type;
    logic [7:0]  tdo_byte;
    logic        last_of_run;
    logic [2:0]  board_features;
    logic [15:0] board_version;
    logic [15:0] fw_version;
    logic        reset_asserted;
    logic        bootloader_request;
  } result_t;

endpackage

@@ sv/jtag_bit_bang_command_engine.sv @@
// A clock-bits beat runs the sequencer through its settle and response states once for
// each of its pairs (0..4), the TCK tick counter timing each state, then through finish.
// Other commands pass the sequencer without leaving idle, so they run back to back while the output slot is free.
// A four-entry command queue lets new beats be accepted while the sequencer works.
// Each result passes through the queue and the output register.
// Synchronous active-low reset empties the queue, releases nRST and restores register defaults.
module jtag_bit_bang_command_engine
  import jbbce_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // system_reset [0], pair_byte [8:1], pairs_valid [11:9], tdo_levels [15:12]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command [7:0]
  input  logic [7:0]             in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdo_byte [7:0], board_features [10:8], board_version [26:11],
  // fw_version [42:27], reset_asserted [43], bootloader_request [44], zero [47:45]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // response_type [7:0]
  output logic [7:0]             out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data
);

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       q_full;
  logic       q_push;
  cmd_entry_t q_push_entry;
  logic       q_pop;
  cmd_entry_t q_head;
  logic       q_not_empty;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SETTLE:    cfg_nxt.settle_ticks   = cfg_data;
        CFG_RESPONSE:  cfg_nxt.response_ticks = cfg_data;
        CFG_BOARD_VER: cfg_nxt.board_version  = cfg_data;
        CFG_FW_VER:    cfg_nxt.fw_version     = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks   <= SETTLE_RST;
      cfg_r.response_ticks <= RESPONSE_RST;
      cfg_r.board_version  <= BOARD_VER_RST;
      cfg_r.fw_version     <= FW_VER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jbbce_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_command    (in_tuser),
    .in_sys_reset  (in_tdata[0]),
    .in_pairs_valid(in_tdata[11:9]),
    .in_tdo        (in_tdata[15:12]),
    .in_eop        (in_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_push_entry)
  );

  jbbce_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_head),
    .not_empty(q_not_empty)
  );

  jbbce_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_not_empty),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {3'b000, res.bootloader_request, res.reset_asserted,
                      res.fw_version, res.board_version,
                      res.board_features, res.tdo_byte};
  assign out_tuser = res.response_type;
  assign out_tlast = res.last_of_run;

endmodule

@@ sv/jbbce_front.sv @@
// Front end: accepts command beats, classifies them and tracks packet length.
module jbbce_front
  import jbbce_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_command,
  input  logic       in_sys_reset,
  input  logic [2:0] in_pairs_valid,
  input  logic [3:0] in_tdo,
  input  logic       in_eop,
  input  logic       q_full,
  output logic       q_push,
  output cmd_entry_t q_entry
);

  localparam int CW = $clog2(MAX_DATA_BYTES + 1);

  logic [CW-1:0] items_r, items_nxt;
  logic          room;
  logic          accept;
  logic          is_clock;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign room     = items_r < CW'(MAX_DATA_BYTES);
  assign is_clock = (in_command == CMD_CLOCK_BITS);

  always_comb begin
    q_entry           = '0;
    q_entry.sys_reset = in_sys_reset;
    q_entry.tdo       = in_tdo;
    q_entry.eop       = in_eop;
    case (in_command)
      CMD_GET_BOARD:  q_entry.kind = KIND_GET_BOARD;
      CMD_RESET:      q_entry.kind = KIND_RESET;
      CMD_BOOTLOADER: q_entry.kind = KIND_BOOT;
      CMD_CLOCK_BITS: q_entry.kind = KIND_CLOCK;
      default:        q_entry.kind = KIND_INVALID;
    endcase
    // Items past the packet limit still close the packet but clock nothing.
    if (!room) begin
      q_entry.npairs = 3'd0;
    end else if (in_pairs_valid > 3'(MAX_PAIRS)) begin
      q_entry.npairs = 3'(MAX_PAIRS);
    end else begin
      q_entry.npairs = in_pairs_valid;
    end
  end

  always_comb begin
    items_nxt = items_r;
    if (accept) begin
      if (!is_clock || in_eop) begin
        items_nxt = '0;
      end else if (room) begin
        items_nxt = items_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r <= '0;
    end else begin
      items_r <= items_nxt;
    end
  end

endmodule

@@ sv/jbbce_fifo.sv @@
// Small command queue between the front end and the bit sequencer.
module jbbce_fifo
  import jbbce_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output cmd_entry_t pop_data,
  output logic       not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_entry_t    slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/jbbce_back.sv @@
// Back end: times each TCK cycle, packs TDO bits and builds response beats.
`include "jtag_bit_bang_command_engine_assert.svh"
module jbbce_back
  import jbbce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       q_valid,
  input  cmd_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_SETTLE   = 2'd1;
  localparam logic [1:0] ST_RESPONSE = 2'd2;
  localparam logic [1:0] ST_FINISH   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] tick_r, tick_nxt;
  cmd_entry_t  work_r, work_nxt;
  logic [1:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        full_r, full_nxt;
  logic [7:0]  full_byte_r, full_byte_nxt;
  logic        nrst_low_r, nrst_low_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  logic        slot_free;
  logic        emit;
  logic        last_bit;
  logic [7:0]  shifted;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = full_r || work_r.eop;
  assign last_bit  = ({1'b0, bit_idx_r} + 3'd1) == work_r.npairs;
  assign shifted   = shift_r | ({7'd0, work_r.tdo[bit_idx_r]} << pos_r);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    work_nxt      = work_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    pos_nxt       = pos_r;
    full_nxt      = full_r;
    full_byte_nxt = full_byte_r;
    nrst_low_nxt  = nrst_low_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid && (slot_free || q_entry.kind == KIND_CLOCK)) begin
          q_pop = 1'b1;
          if (q_entry.kind == KIND_CLOCK) begin
            work_nxt    = q_entry;
            tick_nxt    = 16'd0;
            bit_idx_nxt = 2'd0;
            full_nxt    = 1'b0;
            state_nxt   = (q_entry.npairs == 3'd0) ? ST_FINISH : ST_SETTLE;
          end else begin
            // Any other command drops a partially collected packet.
            shift_nxt     = 8'd0;
            pos_nxt       = 3'd0;
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
            case (q_entry.kind)
              KIND_GET_BOARD: begin
                out_nxt.response_type  = CMD_GET_BOARD;
                out_nxt.board_features = FEAT_SYSTEM_RESET | FEAT_BOOTLOADER;
                out_nxt.board_version  = cfg.board_version;
                out_nxt.fw_version     = cfg.fw_version;
              end
              KIND_RESET: begin
                out_nxt.response_type = CMD_RESET;
                nrst_low_nxt          = q_entry.sys_reset;
              end
              KIND_BOOT: begin
                out_nxt.response_type      = CMD_BOOTLOADER;
                out_nxt.bootloader_request = 1'b1;
              end
              default: begin
                out_nxt.response_type = CMD_INVALID;
              end
            endcase
            out_nxt.reset_asserted = (q_entry.kind == KIND_RESET) ? q_entry.sys_reset
                                                                  : nrst_low_r;
          end
        end
      end
      ST_SETTLE: begin
        if (tick_r == cfg.settle_ticks) begin
          tick_nxt  = 16'd0;
          state_nxt = ST_RESPONSE;
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      ST_RESPONSE: begin
        if (tick_r == cfg.response_ticks) begin
          // Once a final item has filled its byte, later bits are dropped.
          if (!(full_r && work_r.eop)) begin
            if (pos_r == 3'd7) begin
              full_nxt      = 1'b1;
              full_byte_nxt = shifted;
              shift_nxt     = 8'd0;
              pos_nxt       = 3'd0;
            end else begin
              shift_nxt = shifted;
              pos_nxt   = pos_r + 3'd1;
            end
          end
          tick_nxt = 16'd0;
          if (last_bit) begin
            state_nxt = ST_FINISH;
          end else begin
            bit_idx_nxt = bit_idx_r + 2'd1;
            state_nxt   = ST_SETTLE;
          end
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      ST_FINISH: begin
        if (!emit || slot_free) begin
          if (emit) begin
            out_nxt                = '0;
            out_nxt.response_type  = CMD_CLOCK_BITS;
            out_nxt.tdo_byte       = full_r ? full_byte_r : shift_r;
            out_nxt.last_of_run    = work_r.eop;
            out_nxt.reset_asserted = nrst_low_r;
            out_valid_nxt          = 1'b1;
          end
          if (work_r.eop) begin
            shift_nxt = 8'd0;
            pos_nxt   = 3'd0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tick_r      <= tick_nxt;
    work_r      <= work_nxt;
    bit_idx_r   <= bit_idx_nxt;
    full_r      <= full_nxt;
    full_byte_r <= full_byte_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 8'd0;
      pos_r       <= 3'd0;
      nrst_low_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      pos_r       <= pos_nxt;
      nrst_low_r  <= nrst_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `JBBCE_ASSERT_NEVER(a_last_only_clock, out_valid_r && out_r.last_of_run && out_r.response_type != CMD_CLOCK_BITS, "last flag on a non clock-bits response")
  `JBBCE_ASSERT_NEVER(a_boot_flag_type, out_valid_r && out_r.bootloader_request && out_r.response_type != CMD_BOOTLOADER, "bootloader flag on wrong response")
  `JBBCE_ASSERT_IMPLIES(a_busy_is_clock, state_r != ST_IDLE, work_r.kind == KIND_CLOCK, "sequencer busy with a non clock-bits item")
  `JBBCE_ASSERT_NEXT(a_eop_clears, state_r == ST_FINISH && work_r.eop && slot_free, pos_r == 3'd0 && shift_r == 8'd0, "packet end did not clear the TDO byte")

endmodule

@@ sim/tb_jtag_bit_bang_command_engine.sv @@
// Self-checking testbench for the JTAG bit-bang command engine with a response scoreboard.
module tb_jtag_bit_bang_command_engine;
  import jbbce_pkg::*;

  typedef struct {
    logic [7:0] command;
    logic       system_reset;
    logic [7:0] pair_byte;
    logic [2:0] pairs_valid;
    logic [3:0] tdo_levels;
    logic       end_of_packet;
  } probe_cmd_t;

  // Predicts the response stream of the engine and checks what comes out.
  class jtag_response_scoreboard;
    logic [15:0] settle_ticks   = SETTLE_RST;
    logic [15:0] response_ticks = RESPONSE_RST;
    logic [15:0] board_ver      = BOARD_VER_RST;
    logic [15:0] fw_ver         = FW_VER_RST;
    logic [7:0]  tdo_shift      = '0;
    int          bit_pos        = 0;
    int          packet_items   = 0;
    logic        nrst_low       = 1'b0;
    result_t     awaited_responses[$];
    int          errors         = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SETTLE:    settle_ticks = val;
        CFG_RESPONSE:  response_ticks = val;
        CFG_BOARD_VER: board_ver = val;
        CFG_FW_VER:    fw_ver = val;
        default: ;
      endcase
    endfunction

    function void clear_packet();
      tdo_shift = '0;
      bit_pos = 0;
      packet_items = 0;
    endfunction

    function void note_command(probe_cmd_t c);
      result_t    resp;
      logic [7:0] full_byte;
      bit         full;
      bit         emit;
      int         npairs;
      resp = '0;
      emit = 1'b1;
      full = 1'b0;
      full_byte = '0;
      if (c.command == CMD_CLOCK_BITS) begin
        npairs = (c.pairs_valid > MAX_PAIRS) ? MAX_PAIRS : c.pairs_valid;
        // Items beyond the packet limit still close the packet but clock nothing.
        if (packet_items < MAX_DATA_BYTES_DEF) begin
          packet_items++;
          for (int k = 0; k < npairs; k++) begin
            // Once a final item has filled its byte, its remaining bits are lost.
            if (!(full && c.end_of_packet)) begin
              tdo_shift[bit_pos] = c.tdo_levels[k];
              bit_pos++;
              if (bit_pos == 8) begin
                full = 1'b1;
                full_byte = tdo_shift;
                tdo_shift = '0;
                bit_pos = 0;
              end
            end
          end
        end
        emit = full || c.end_of_packet;
        resp.response_type = CMD_CLOCK_BITS;
        resp.tdo_byte = full ? full_byte : tdo_shift;
        resp.last_of_run = c.end_of_packet;
        if (c.end_of_packet) clear_packet();
      end else begin
        clear_packet();
        case (c.command)
          CMD_GET_BOARD: begin
            resp.response_type = CMD_GET_BOARD;
            resp.board_features = FEAT_SYSTEM_RESET | FEAT_BOOTLOADER;
            resp.board_version = board_ver;
            resp.fw_version = fw_ver;
          end
          CMD_RESET: begin
            nrst_low = c.system_reset;
            resp.response_type = CMD_RESET;
          end
          CMD_BOOTLOADER: begin
            resp.response_type = CMD_BOOTLOADER;
            resp.bootloader_request = 1'b1;
          end
          default: resp.response_type = CMD_INVALID;
        endcase
      end
      resp.reset_asserted = nrst_low;
      if (emit) awaited_responses.push_back(resp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_responses.size() == 0) begin
        $error("response beat with nothing expected: type %0h", got.response_type);
        errors++;
        return;
      end
      want = awaited_responses.pop_front();
      compare_field("response_type", want.response_type, got.response_type);
      compare_field("tdo_byte", want.tdo_byte, got.tdo_byte);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
      compare_field("board_features", want.board_features, got.board_features);
      compare_field("board_version", want.board_version, got.board_version);
      compare_field("fw_version", want.fw_version, got.fw_version);
      compare_field("reset_asserted", want.reset_asserted, got.reset_asserted);
      compare_field("bootloader_request", want.bootloader_request, got.bootloader_request);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [7:0]             in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [7:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  jtag_response_scoreboard sb;
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  jtag_bit_bang_command_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Response side backpressure, with a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.response_type      = out_tuser;
      got.tdo_byte           = out_tdata[7:0];
      got.last_of_run        = out_tlast;
      got.board_features     = out_tdata[10:8];
      got.board_version      = out_tdata[26:11];
      got.fw_version         = out_tdata[42:27];
      got.reset_asserted     = out_tdata[43];
      got.bootloader_request = out_tdata[44];
      sb.check_result(got);
    end
  end

  function automatic probe_cmd_t clock_item(logic [7:0] pb, logic [2:0] pv, logic [3:0] tdo,
                                            logic eop);
    probe_cmd_t c;
    c.command = CMD_CLOCK_BITS;
    c.system_reset = 1'($urandom_range(1));
    c.pair_byte = pb;
    c.pairs_valid = pv;
    c.tdo_levels = tdo;
    c.end_of_packet = eop;
    return c;
  endfunction

  function automatic probe_cmd_t plain_item(logic [7:0] cmd, logic sys);
    probe_cmd_t c;
    c.command = cmd;
    c.system_reset = sys;
    c.pair_byte = 8'($urandom_range(255));
    c.pairs_valid = 3'($urandom_range(7));
    c.tdo_levels = 4'($urandom_range(15));
    c.end_of_packet = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic probe_cmd_t random_clock(logic eop);
    logic [2:0] pv;
    pv = ($urandom_range(9) < 6) ? 3'(MAX_PAIRS) : 3'($urandom_range(7));
    return clock_item(8'($urandom_range(255)), pv, 4'($urandom_range(15)), eop);
  endfunction

  function automatic probe_cmd_t random_other();
    case ($urandom_range(3))
      0: return plain_item(CMD_GET_BOARD, 1'($urandom_range(1)));
      1: return plain_item(CMD_RESET, 1'($urandom_range(1)));
      2: return plain_item(CMD_BOOTLOADER, 1'($urandom_range(1)));
      default: return plain_item(8'($urandom_range(255)), 1'($urandom_range(1)));
    endcase
  endfunction

  // Starts and ends at a falling edge; tvalid is left high for a following beat.
  task automatic send_item(probe_cmd_t c);
    while (!no_gaps && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.command;
    in_tlast  <= c.end_of_packet;
    in_tdata  <= {c.tdo_levels, c.pairs_valid, c.pair_byte, c.system_reset};
    do @(posedge clk); while (!in_tready);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [15:0] settle, logic [15:0] resp_wait,
                              logic [15:0] board_ver, logic [15:0] fw_ver);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_RESPONSE, resp_wait);
    write_reg(CFG_BOARD_VER, board_ver);
    write_reg(CFG_FW_VER, fw_ver);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain(int extra_cycles);
    in_tvalid <= 1'b0;
    while (sb.awaited_responses.size() != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  // A closing get-board beat always answers, so once it is back the sequencer is empty.
  task automatic close_phase();
    send_item(plain_item(CMD_GET_BOARD, 1'b0));
    drain(16);
  endtask

  task automatic run_random(int target);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // Well-formed packet; now and then one near or past the packet limit.
        len = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_item(random_clock(i == len - 1));
        sent += len;
      end else if (kind < 65) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_item(random_clock(1'b0));
        send_item(random_other());
        sent += len + 1;
      end else begin
        send_item(random_other());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset settings.
    send_item(plain_item(CMD_GET_BOARD, 1'b0));
    send_item(plain_item(CMD_INVALID, 1'b1));
    send_item(plain_item(8'hFF, 1'b0));
    send_item(plain_item(CMD_CLOCK_BITS - 8'd1, 1'b1));
    send_item(plain_item(CMD_RESET, 1'b1));
    send_item(plain_item(CMD_GET_BOARD, 1'b0));
    send_item(plain_item(CMD_BOOTLOADER, 1'b0));
    send_item(plain_item(CMD_RESET, 1'b0));
    send_item(clock_item(8'hFF, 3'd4, 4'hF, 1'b0));
    send_item(clock_item(8'h00, 3'd4, 4'h5, 1'b0));
    send_item(clock_item(8'hA5, 3'd7, 4'hA, 1'b0));
    send_item(clock_item(8'h5A, 3'd0, 4'hF, 1'b1));
    send_item(clock_item(8'h00, 3'd0, 4'h0, 1'b1));
    send_item(clock_item(8'h3C, 3'd3, 4'h7, 1'b0));
    send_item(clock_item(8'hC3, 3'd3, 4'h2, 1'b0));
    send_item(clock_item(8'hFF, 3'd3, 4'hD, 1'b1));
    send_item(clock_item(8'h12, 3'd2, 4'h3, 1'b0));
    send_item(plain_item(CMD_GET_BOARD, 1'b0));
    send_item(clock_item(8'h34, 3'd1, 4'h1, 1'b1));
    send_item(clock_item(8'h00, 3'd5, 4'hF, 1'b0));
    send_item(clock_item(8'hFF, 3'd6, 4'h0, 1'b0));
    send_item(clock_item(8'h81, 3'd4, 4'hF, 1'b1));
    send_item(plain_item(CMD_RESET, 1'b1));
    send_item(clock_item(8'h7E, 3'd2, 4'hC, 1'b1));
    send_item(plain_item(CMD_RESET, 1'b0));
    close_phase();

    // Fastest clocking; the receiver stalls long at the start so the queue fills.
    program_regs(16'd0, 16'd0, 16'h0000, 16'hFFFF);
    hold_requests++;
    run_random(450);
    close_phase();

    // Longest tick counts, kept to a single bit.
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(clock_item(8'($urandom_range(255)), 3'd1, 4'($urandom_range(15)), 1'b1));
    close_phase();

    program_regs(16'($urandom_range(1, 5)), 16'($urandom_range(0, 5)),
                 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
    no_gaps = 1'b1;
    run_random(150);
    no_gaps = 1'b0;
    run_random(300);
    close_phase();

    program_regs(16'd3, 16'd1, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
    run_random(420);
    drain(4 * (int'(sb.settle_ticks) + int'(sb.response_ticks) + 2) + 12);

    if (sb.errors == 0) begin
      $display("tb_jtag_bit_bang_command_engine OK");
    end else begin
      $display("tb_jtag_bit_bang_command_engine NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_jtag_bit_bang_command_engine NOT OK");
    $finish;
  end

endmodule
